// ----- rtl/dfs_pkg.sv -----
// Shared types and constants of the depth-first topological sort block.
// No dependencies.
package dfs_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int VW = 7;
  localparam int VIW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges) + 1;
  localparam int EIW = $clog2(MaxEdges);
  localparam int DW = $clog2(MaxVertices) + 1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_IGNORE = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DROP = 2'd1;
  localparam logic [1:0] OP_RUN = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [EW-1:0] LIST_END = EW'(MaxEdges);

  typedef struct packed {
    logic [1:0] op;
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [VW-1:0] n;
  } work_t;

endpackage

// ----- rtl/dfs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/dfs_front.sv -----
// Front end: accepts commands, classifies them and queues them for the engine.
// Depends on dfs_pkg.
module dfs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [1:0]              cmd,
  input  logic [dfs_pkg::VW-1:0]  src,
  input  logic [dfs_pkg::VW-1:0]  dst,
  input  logic [dfs_pkg::VW-1:0]  vcount,
  output logic                    q_valid,
  input  logic                    q_ready,
  output dfs_pkg::work_t          q_item
);
  // Two-entry queue decouples acceptance from the engine.
  dfs_pkg::work_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r;
  logic [dfs_pkg::VW-1:0] n_eff;
  logic [dfs_pkg::EW-1:0] fill_r, fill_nxt;
  dfs_pkg::work_t w;
  logic push, pop, keep;

  assign n_eff = (vcount > dfs_pkg::VW'(dfs_pkg::MaxVertices)) ?
                 dfs_pkg::VW'(dfs_pkg::MaxVertices) : vcount;

  // The edge fill count is tracked here so drops are decided at classification.
  always_comb begin
    w.src = src;
    w.dst = dst;
    w.n = n_eff;
    fill_nxt = fill_r;
    keep = 1'b1;
    case (cmd)
      dfs_pkg::CMD_ADD: begin
        if (src == '0 || src > n_eff || dst == '0 || dst > n_eff ||
            fill_r >= dfs_pkg::EW'(dfs_pkg::MaxEdges)) begin
          w.op = dfs_pkg::OP_DROP;
        end else begin
          w.op = dfs_pkg::OP_ADD;
          fill_nxt = fill_r + 1'b1;
        end
      end
      dfs_pkg::CMD_RUN: w.op = dfs_pkg::OP_RUN;
      dfs_pkg::CMD_CLEAR: begin
        w.op = dfs_pkg::OP_CLEAR;
        fill_nxt = '0;
      end
      default: begin
        w.op = dfs_pkg::OP_CLEAR;
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready && keep;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  assign rd_nxt = pop ? ~rd_r : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      fill_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (in_tvalid && in_tready) begin
        fill_r <= fill_nxt;
      end
    end
    if (push) begin
      q_r[wr_r] <= w;
    end
  end
endmodule

// ----- rtl/dfs_engine.sv -----
// Back end: edge store, depth-first walk and emission of the finish order.
// Depends on dfs_pkg and dfs_ram.
module dfs_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  dfs_pkg::work_t         q_item,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [dfs_pkg::VW-1:0] out_vertex_id,
  output logic                   out_last,
  output logic                   out_dropped
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;
  localparam logic [3:0] S_TOP = 4'd2;
  localparam logic [3:0] S_STEP = 4'd3;
  localparam logic [3:0] S_EDGE = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_EMITW = 4'd6;
  localparam logic [3:0] S_POPW = 4'd7;
  localparam logic [3:0] S_ADD = 4'd8;
  localparam logic [3:0] S_HEAD = 4'd9;

  localparam int VIW = dfs_pkg::VIW;
  localparam int EW = dfs_pkg::EW;
  localparam int EIW = dfs_pkg::EIW;
  localparam int DW = dfs_pkg::DW;
  localparam int VW = dfs_pkg::VW;

  logic [3:0] st_r, st_nxt;
  logic [VW-1:0] n_r;
  logic [VW-1:0] root_r;
  logic [DW-1:0] depth_r;
  logic [DW-1:0] done_r;
  logic [EW-1:0] fill_r;
  // A list head is only trusted once written since the last clear.
  logic [dfs_pkg::MaxVertices-1:0] head_vld_r;
  // A vertex is white while its bit is clear; gray and black are not told apart.
  logic [dfs_pkg::MaxVertices-1:0] seen_r;
  logic [VW-1:0] top_v_r;
  logic [EW-1:0] top_c_r;

  logic ovalid_r, olast_r, odrop_r;
  logic [VW-1:0] oid_r;

  // Edge store memories.
  logic e_we;
  logic [EIW-1:0] e_waddr, e_raddr;
  logic [VW-1:0] tgt_rd;
  logic [EW-1:0] lnk_rd;
  logic [EW-1:0] lnk_wd;

  // List heads.
  logic h_we;
  logic [VIW-1:0] h_raddr;
  logic [EW-1:0] h_rd;

  // Walk stack (vertex, cursor) and finish order.
  logic s_we;
  logic [VIW-1:0] s_waddr, s_raddr;
  logic [VW+EW-1:0] s_wd, s_rd;
  logic f_we;
  logic [VIW-1:0] f_waddr, f_raddr;
  logic [VW-1:0] f_rd;

  logic [VIW-1:0] src_i;
  logic [VIW-1:0] top_i;
  logic free;

  assign src_i = VIW'(q_item.src - 1'b1);
  assign top_i = VIW'(top_v_r - 1'b1);
  assign e_waddr = fill_r[EIW-1:0];
  assign e_we = (st_r == S_ADD);
  assign h_we = (st_r == S_ADD);
  assign lnk_wd = head_vld_r[src_i] ? h_rd : dfs_pkg::LIST_END;
  assign e_raddr = top_c_r[EIW-1:0];
  assign free = !ovalid_r || out_tready;

  dfs_ram #(.Width(VW), .Depth(dfs_pkg::MaxEdges)) u_tgt (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(q_item.dst), .raddr(e_raddr), .rdata(tgt_rd));
  dfs_ram #(.Width(EW), .Depth(dfs_pkg::MaxEdges)) u_lnk (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(lnk_wd), .raddr(e_raddr), .rdata(lnk_rd));
  dfs_ram #(.Width(EW), .Depth(dfs_pkg::MaxVertices)) u_head (
    .clk, .we(h_we), .waddr(src_i), .wdata(fill_r), .raddr(h_raddr), .rdata(h_rd));
  dfs_ram #(.Width(VW + EW), .Depth(dfs_pkg::MaxVertices)) u_stk (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wd), .raddr(s_raddr), .rdata(s_rd));
  dfs_ram #(.Width(VW), .Depth(dfs_pkg::MaxVertices)) u_fin (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(top_v_r), .raddr(f_raddr), .rdata(f_rd));

  logic [VIW-1:0] tgt_i;
  logic tgt_ok;
  assign tgt_i = VIW'(tgt_rd - 1'b1);
  assign tgt_ok = (tgt_rd != '0) && (tgt_rd <= n_r) && !seen_r[tgt_i] &&
                  (depth_r < DW'(dfs_pkg::MaxVertices));

  // The top frame lives in registers; frames below it sit in the stack memory.
  always_comb begin
    st_nxt = st_r;
    s_we = 1'b0;
    s_waddr = VIW'(depth_r - 1'b1);
    s_wd = {top_v_r, lnk_rd};
    s_raddr = VIW'(depth_r - 1'b1);
    f_we = 1'b0;
    f_waddr = done_r[VIW-1:0];
    f_raddr = VIW'(done_r - 1'b1);
    h_raddr = src_i;
    q_ready = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            dfs_pkg::OP_ADD: st_nxt = S_ADD;
            dfs_pkg::OP_CLEAR: q_ready = 1'b1;
            dfs_pkg::OP_DROP: q_ready = free;
            dfs_pkg::OP_RUN: begin
              q_ready = free;
              if (free && q_item.n != '0) begin
                st_nxt = S_ROOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        q_ready = 1'b1;
        st_nxt = S_IDLE;
      end
      S_ROOT: begin
        h_raddr = VIW'(root_r - 1'b1);
        if (root_r > n_r) begin
          st_nxt = S_EMIT;
        end else if (!seen_r[VIW'(root_r - 1'b1)]) begin
          st_nxt = S_HEAD;
        end
      end
      S_HEAD: st_nxt = S_STEP;
      S_STEP: begin
        if (top_c_r == dfs_pkg::LIST_END) begin
          f_we = (done_r < DW'(dfs_pkg::MaxVertices));
          st_nxt = (depth_r == DW'(1)) ? S_ROOT : S_POPW;
        end else begin
          st_nxt = S_EDGE;
        end
      end
      S_POPW: st_nxt = S_TOP;
      S_TOP: st_nxt = S_STEP;
      S_EDGE: begin
        h_raddr = tgt_i;
        if (tgt_ok) begin
          // Push the current frame with its advanced cursor, then enter the target.
          s_we = 1'b1;
          st_nxt = S_HEAD;
        end else begin
          st_nxt = S_STEP;
        end
      end
      S_EMIT: st_nxt = S_EMITW;
      S_EMITW: begin
        if (free) begin
          st_nxt = (done_r == DW'(1)) ? S_IDLE : S_EMIT;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      fill_r <= '0;
      ovalid_r <= 1'b0;
      head_vld_r <= '0;
      seen_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            case (q_item.op)
              dfs_pkg::OP_CLEAR: begin
                fill_r <= '0;
                head_vld_r <= '0;
                seen_r <= '0;
              end
              dfs_pkg::OP_DROP: begin
                ovalid_r <= 1'b1;
                oid_r <= '0;
                olast_r <= 1'b1;
                odrop_r <= 1'b1;
              end
              dfs_pkg::OP_RUN: begin
                n_r <= q_item.n;
                root_r <= VW'(1);
                done_r <= '0;
                if (q_item.n == '0) begin
                  ovalid_r <= 1'b1;
                  oid_r <= '0;
                  olast_r <= 1'b1;
                  odrop_r <= 1'b0;
                end else begin
                  seen_r <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          head_vld_r[src_i] <= 1'b1;
          fill_r <= fill_r + 1'b1;
        end
        S_ROOT: begin
          if (root_r <= n_r) begin
            root_r <= root_r + 1'b1;
            if (!seen_r[VIW'(root_r - 1'b1)]) begin
              seen_r[VIW'(root_r - 1'b1)] <= 1'b1;
              top_v_r <= root_r;
              depth_r <= DW'(1);
            end
          end
        end
        S_HEAD: top_c_r <= head_vld_r[top_i] ? h_rd : dfs_pkg::LIST_END;
        S_STEP: begin
          if (top_c_r == dfs_pkg::LIST_END) begin
            if (done_r < DW'(dfs_pkg::MaxVertices)) begin
              done_r <= done_r + 1'b1;
            end
            depth_r <= depth_r - 1'b1;
          end
        end
        S_TOP: {top_v_r, top_c_r} <= s_rd;
        S_EDGE: begin
          if (tgt_ok) begin
            seen_r[tgt_i] <= 1'b1;
            top_v_r <= tgt_rd;
            depth_r <= depth_r + 1'b1;
          end else begin
            top_c_r <= lnk_rd;
          end
        end
        S_EMITW: begin
          if (free) begin
            ovalid_r <= 1'b1;
            oid_r <= f_rd;
            olast_r <= (done_r == DW'(1));
            odrop_r <= 1'b0;
            done_r <= done_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_vertex_id = oid_r;
  assign out_last = olast_r;
  assign out_dropped = odrop_r;
endmodule

// ----- rtl/dfs_topological_sort.sv -----
// Top level of the depth-first topological sort block.
// An edge load reads the list head, then stores the edge; the engine takes its next
// command only after the store. A run walks the whole graph before the first vertex;
// results then leave in reverse finish order, each sent once the output is free.
// rst_n is synchronous: lists empty, colors white, vertex_count 1.
// Depends on dfs_pkg, dfs_front, dfs_engine and dfs_ram.
module dfs_topological_sort (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd[1:0], src_vertex[8:2], dst_vertex[15:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // vertex_id[6:0], zero[7]
  output logic        out_tlast,
  output logic        out_tuser,  // edge_dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  logic [dfs_pkg::VW-1:0] vcount_r;
  logic q_valid, q_ready;
  dfs_pkg::work_t q_item;
  logic [dfs_pkg::VW-1:0] vid;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= dfs_pkg::VW'(1);
    end else if (cfg_valid) begin
      vcount_r <= cfg_data;
    end
  end

  dfs_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .cmd(in_tdata[1:0]), .src(in_tdata[8:2]), .dst(in_tdata[15:9]),
    .vcount(vcount_r), .q_valid, .q_ready, .q_item);

  dfs_engine u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_vertex_id(vid),
    .out_last(out_tlast), .out_dropped(out_tuser));

  assign out_tdata = {1'b0, vid};

  a_drop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && vid == '0) else $error("drop not final");
  a_q_ready_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> q_valid) else $error("queue pop without data");
endmodule

// ----- bench/dfs_checker.sv -----
// Checker for the depth-first topological sort block: watches the input,
// result and register channels, predicts the emitted order and compares.
// Depends on dfs_pkg.
`timescale 1ns / 1ps
module dfs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  localparam int MaxVertices = dfs_pkg::MaxVertices;
  localparam int MaxEdges = dfs_pkg::MaxEdges;

  typedef struct packed {
    logic [6:0] vid;
    logic       last;
    logic       dropped;
  } order_item_t;

  order_item_t order_q[$];

  logic [6:0] n_vert;
  int unsigned head[MaxVertices];
  logic [6:0] tgt[MaxEdges];
  int unsigned lnk[MaxEdges];
  int unsigned fill;
  logic [1:0] color[MaxVertices];
  logic [6:0] stk_v[MaxVertices];
  int unsigned stk_c[MaxVertices];
  logic [6:0] fin[MaxVertices];

  function automatic int unsigned eff_count();
    return (n_vert > MaxVertices) ? MaxVertices : n_vert;
  endfunction

  task automatic wipe_graph();
    for (int k = 0; k < MaxVertices; k++) begin
      head[k] = MaxEdges;
      color[k] = 2'd0;
    end
    fill = 0;
  endtask

  task automatic push_order(logic [6:0] v, logic l, logic d);
    order_item_t it;
    it.vid = v; it.last = l; it.dropped = d;
    order_q.push_back(it);
  endtask

  task automatic predict_sort();
    int unsigned n, done, depth, e, t;
    logic [6:0] v;
    n = eff_count();
    done = 0;
    if (n == 0) begin
      push_order(7'd0, 1'b1, 1'b0);
      return;
    end
    for (int k = 0; k < MaxVertices; k++) color[k] = 2'd0;
    for (int r = 1; r <= n; r++) begin
      if (color[r-1] != 2'd0) continue;
      color[r-1] = 2'd1;
      stk_v[0] = 7'(r); stk_c[0] = head[r-1];
      depth = 1;
      while (depth > 0) begin
        e = stk_c[depth-1];
        if (e < MaxEdges) begin
          t = tgt[e];
          stk_c[depth-1] = lnk[e];
          if (t >= 1 && t <= n && color[t-1] == 2'd0 && depth < MaxVertices) begin
            color[t-1] = 2'd1;
            stk_v[depth] = 7'(t); stk_c[depth] = head[t-1];
            depth++;
          end
        end else begin
          v = stk_v[depth-1];
          color[(v - 1) & (MaxVertices - 1)] = 2'd2;
          if (done < MaxVertices) begin
            fin[done] = v;
            done++;
          end
          depth--;
        end
      end
    end
    for (int k = 0; k < done; k++)
      push_order(fin[done-1-k], k + 1 == done, 1'b0);
  endtask

  always @(posedge clk) begin
    logic [1:0] cmd;
    logic [6:0] s, d;
    order_item_t got, exp_it;
    if (!rst_n) begin
      n_vert <= 7'd1;
      wipe_graph();
      order_q.delete();
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) n_vert <= cfg_data;
      if (in_tvalid && in_tready) begin
        cmd = in_tdata[1:0];
        s = in_tdata[8:2];
        d = in_tdata[15:9];
        if (cmd == dfs_pkg::CMD_ADD) begin
          if (s < 1 || s > eff_count() || d < 1 || d > eff_count() || fill >= MaxEdges)
            push_order(7'd0, 1'b1, 1'b1);
          else begin
            tgt[fill] = d;
            lnk[fill] = head[s-1];
            head[s-1] = fill;
            fill++;
          end
        end else if (cmd == dfs_pkg::CMD_RUN) predict_sort();
        else if (cmd == dfs_pkg::CMD_CLEAR) wipe_graph();
      end
      if (out_tvalid && out_tready) begin
        got.vid = out_tdata[6:0]; got.last = out_tlast; got.dropped = out_tuser;
        result_count <= result_count + 1;
        if (order_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got vid=%0d last=%0d drop=%0d",
                   $realtime, got.vid, got.last, got.dropped);
          fail_count <= fail_count + 1;
        end else begin
          exp_it = order_q.pop_front();
          if (got !== exp_it || out_tdata[7] !== 1'b0) begin
            $display("%0t: mismatch expected vid=%0d last=%0d drop=%0d",
                     $realtime, exp_it.vid, exp_it.last, exp_it.dropped);
            $display("%0t:          got vid=%0d last=%0d drop=%0d pad=%0d",
                     $realtime, got.vid, got.last, got.dropped, out_tdata[7]);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= order_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the depth-first topological sort block: drives edges,
// runs and clears under random idling and rewrites vertex_count between phases.
// Depends on dfs_pkg, dfs_topological_sort and dfs_checker.
`timescale 1ns / 1ps
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast, out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_data = 7'd1;
  int fail_count, pending, result_count;
  int cycle = 0;
  bit calm = 1'b0;
  int n_items = 0;

  localparam int CycleLimit = 2000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dfs_topological_sort u_top (.*);

  dfs_checker u_chk (.*);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout at %0t", $realtime);
      $display("status: fail");
      $finish;
    end
  end

  // Result side stalls at random, with probability 38 in 100, except during the calm stretch.
  always @(negedge clk)
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 38);

  task automatic send(logic [1:0] cmd, logic [6:0] s, logic [6:0] d);
    while (!calm && $urandom_range(99) < 38) @(negedge clk);
    in_tdata = {d, s, cmd};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    n_items++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic set_count(logic [6:0] n);
    drain();
    cfg_data = n;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly in-range edges plus a few out-of-range ones, then a sort.
  task automatic random_graph(int n, int edges);
    logic [6:0] s, d;
    for (int k = 0; k < edges; k++) begin
      if ($urandom_range(9) == 0) begin
        s = 7'($urandom); d = 7'($urandom);
      end else begin
        s = 7'($urandom_range(n, 1)); d = 7'($urandom_range(n, 1));
      end
      if ($urandom_range(19) == 0) send(dfs_pkg::CMD_IGNORE, s, d);
      else send(dfs_pkg::CMD_ADD, s, d);
    end
    send(dfs_pkg::CMD_RUN, 7'($urandom), 7'($urandom));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // Directed: single vertex, rejected edges, chain, cycle, clear, empty graph.
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    send(dfs_pkg::CMD_ADD, 7'd1, 7'd2);
    send(dfs_pkg::CMD_ADD, 7'd0, 7'd1);
    set_count(7'd5);
    send(dfs_pkg::CMD_ADD, 7'd1, 7'd2);
    send(dfs_pkg::CMD_ADD, 7'd2, 7'd3);
    send(dfs_pkg::CMD_ADD, 7'd3, 7'd1);
    send(dfs_pkg::CMD_ADD, 7'd1, 7'd5);
    send(dfs_pkg::CMD_ADD, 7'd5, 7'd6);
    send(dfs_pkg::CMD_ADD, 7'd127, 7'd127);
    send(dfs_pkg::CMD_IGNORE, 7'd1, 7'd4);
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    send(dfs_pkg::CMD_CLEAR, 7'd0, 7'd0);
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    set_count(7'd0);
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    send(dfs_pkg::CMD_ADD, 7'd1, 7'd1);
    set_count(7'd127);
    send(dfs_pkg::CMD_ADD, 7'd64, 7'd1);
    send(dfs_pkg::CMD_ADD, 7'd1, 7'd64);
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    set_count(7'd3);
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    send(dfs_pkg::CMD_CLEAR, 7'd0, 7'd0);
    // Fill the edge store past capacity in one stretch with no idling.
    set_count(7'd64);
    calm = 1'b1;
    for (int k = 0; k < dfs_pkg::MaxEdges + 2; k++)
      send(dfs_pkg::CMD_ADD, 7'($urandom_range(64, 1)), 7'($urandom_range(64, 1)));
    send(dfs_pkg::CMD_RUN, 7'd0, 7'd0);
    send(dfs_pkg::CMD_CLEAR, 7'd0, 7'd0);
    calm = 1'b0;
    // Short random phases with a range of vertex counts.
    while (n_items < 300) begin
      set_count(7'($urandom_range(12, 1)));
      random_graph(u_chk.eff_count(), $urandom_range(10, 1));
      if ($urandom_range(2) == 0)
        send(dfs_pkg::CMD_CLEAR, 7'($urandom), 7'($urandom));
      if ($urandom_range(3) == 0) drain();
    end
    drain();
    $display("Covered edge loads, drops, full store, clears, ignored commands and");
    $display("sorts on 0 to 64 vertices: %0d items, %0d results.", n_items, result_count);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- dfs_topological_sort.f -----
rtl/dfs_pkg.sv
rtl/dfs_ram.sv
rtl/dfs_front.sv
rtl/dfs_engine.sv
rtl/dfs_topological_sort.sv
bench/dfs_checker.sv
bench/tb.sv
